// ===== rtl/core/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants for the sleep minute classifier.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned MAG_W    = 17;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned PHASE_W  = 6;

    // last second of a minute
    localparam logic [PHASE_W-1:0] PHASE_LAST = 6'd59;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [HOUR_W-1:0] window_start_hour;
        logic [HOUR_W-1:0] window_end_hour;
        logic [MAG_W-1:0]  motion_threshold;
        logic [CNT_W-1:0]  light_still_seconds;
        logic [CNT_W-1:0]  deep_still_seconds;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0]  accel_x;
        logic signed [15:0]  accel_y;
        logic signed [15:0]  accel_z;
        logic [CNT_W-1:0]    step_total;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MINUTE_W-1:0] minute_of_hour;
        logic                is_charging;
        logic                is_worn;
    } sample_t;

    typedef struct packed {
        logic [MAG_W-1:0]   prev_magnitude;
        logic [CNT_W-1:0]   still_count;
        logic [CNT_W-1:0]   prev_steps;
        logic               moved_mark;
        logic [PHASE_W-1:0] second_phase;
        logic               armed_mark;
        logic [CNT_W-1:0]   deep_total;
        logic [CNT_W-1:0]   light_total;
    } state_t;

    // per-sample status from the update logic
    typedef struct packed {
        logic save_record;
        logic night_clear;
        logic counted;
    } status_t;

endpackage

// ===== rtl/core/smc_step.sv =====
// ----------------------------------------------------------------------------
// smc_step
// Next-state logic for one accepted sample: stillness tracking, minute tick,
// nightly clear and sleep minute counting.
// ----------------------------------------------------------------------------
module smc_step
(
    input  smc_pkg::cfg_t    cfg,
    input  smc_pkg::sample_t sample,
    input  smc_pkg::state_t  state,
    output smc_pkg::state_t  state_next,
    output smc_pkg::status_t status
);
    import smc_pkg::*;

    logic signed [17:0] sum;
    logic [17:0]        abs_sum;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   diff;
    logic [CNT_W-1:0]   still_upd;
    logic [PHASE_W-1:0] phase_upd;
    logic               active;
    logic               tick;
    logic               in_window;
    logic               walked;

    assign sum = 18'(sample.accel_x) + 18'(sample.accel_y) + 18'(sample.accel_z);
    assign abs_sum = sum[17] ? 18'(-sum) : 18'(sum);
    assign mag = abs_sum[MAG_W-1:0];
    assign diff = (mag > state.prev_magnitude) ? mag - state.prev_magnitude
                                               : state.prev_magnitude - mag;

    assign active = !sample.is_charging && sample.is_worn;
    assign tick = (state.second_phase == '0);
    assign in_window = (sample.hour_of_day >= cfg.window_start_hour)
                    || (sample.hour_of_day < cfg.window_end_hour);
    assign walked = (state.prev_steps < sample.step_total) && (state.prev_steps != '0);

    // saturating stillness count, compared after this sample's update
    assign still_upd = (diff >= cfg.motion_threshold) ? '0
                     : (state.still_count == CNT_MAX) ? CNT_MAX
                     : state.still_count + 1'b1;
    assign phase_upd = (state.second_phase >= PHASE_LAST) ? '0
                     : state.second_phase + 1'b1;

    always_comb
    begin
        state_next = state;
        status     = '0;
        if (active)
        begin
            state_next.still_count    = still_upd;
            state_next.prev_magnitude = mag;
            state_next.second_phase   = phase_upd;
            state_next.prev_steps     = sample.step_total;
            if (tick)
            begin
                if (walked || state.moved_mark)
                begin
                    state_next.moved_mark = !state.moved_mark || walked;
                end
                if (in_window)
                begin
                    if (sample.hour_of_day == cfg.window_start_hour
                        && sample.minute_of_hour == '0)
                    begin
                        if (state.armed_mark)
                        begin
                            state_next.armed_mark     = 1'b0;
                            state_next.prev_magnitude = '0;
                            state_next.still_count    = '0;
                            state_next.moved_mark     = 1'b0;
                            state_next.deep_total     = '0;
                            state_next.light_total    = '0;
                            state_next.second_phase   = PHASE_W'(1);
                            status.save_record        = 1'b1;
                            status.night_clear        = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.armed_mark = 1'b1;
                        if (state.prev_steps == sample.step_total
                            && still_upd >= cfg.light_still_seconds)
                        begin
                            if (still_upd >= cfg.deep_still_seconds)
                            begin
                                if (state.deep_total != CNT_MAX)
                                begin
                                    state_next.deep_total = state.deep_total + 1'b1;
                                end
                            end
                            else if (state.light_total != CNT_MAX)
                            begin
                                state_next.light_total = state.light_total + 1'b1;
                            end
                            status.save_record = 1'b1;
                            status.counted     = 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/sleep_minute_classifier.sv =====
// ----------------------------------------------------------------------------
// sleep_minute_classifier
// Counts deep and light sleep minutes inside a nightly window from
// one-per-second wrist sensor samples.
// ----------------------------------------------------------------------------
// Each sample transfer on the s_ stream carries three accelerometer axes, the
// running step count, the time of day and the charging and worn flags. The
// block takes one sample per clock while m_tready is high: the sample is
// captured in an input register, the whole update (magnitude, stillness
// count, minute tick, night window, totals) is one combinational pass in
// smc_step, and the result is registered for the m_ stream. The rate is set
// by the state update loop, which closes through the state register alone.
// Samples taken while charging or off the wrist leave all state alone and
// return save_record 0 with the current totals. A result waiting on m_tready
// holds the input register, and s_tready drops only when both registers are
// full and the output is stalled. The thresholds and window hours sit on an
// APB port (always ready) and are meant to be changed only while no sample is
// in flight.
// ----------------------------------------------------------------------------
module sleep_minute_classifier
(
    input  logic        clk,
    input  logic        rst_n,

    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] step_total,
    // [68:64] hour_of_day, [74:69] minute_of_hour, [79:75] zero
    input  logic [79:0] s_tdata,
    // [0] is_charging, [1] is_worn
    input  logic [1:0]  s_tuser,

    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] deep_minutes, [31:16] light_minutes
    output logic [31:0] m_tdata,
    // [0] save_record
    output logic        m_tuser,

    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smc_pkg::*;

    // register word indexes (byte address / 4)
    localparam logic [2:0] REG_WIN_START = 3'd0;
    localparam logic [2:0] REG_WIN_END   = 3'd1;
    localparam logic [2:0] REG_MOTION    = 3'd2;
    localparam logic [2:0] REG_LIGHT     = 3'd3;
    localparam logic [2:0] REG_DEEP      = 3'd4;

    localparam cfg_t CFG_RESET = '{
        window_start_hour:   5'd20,
        window_end_hour:     5'd8,
        motion_threshold:    17'd120,
        light_still_seconds: 16'd60,
        deep_still_seconds:  16'd600
    };

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       cfg_write;
    logic [2:0] reg_index;

    sample_t    sample_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic       in_take;
    logic       advance;

    state_t     state_reg;
    state_t     state_next;
    status_t    status;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       save_reg;
    logic [CNT_W-1:0] deep_reg;
    logic [CNT_W-1:0] light_reg;

    // ------------------------------------------------------------------
    // APB: zero wait states, write on the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_WIN_START: cfg_next.window_start_hour   = pwdata[HOUR_W-1:0];
                REG_WIN_END:   cfg_next.window_end_hour     = pwdata[HOUR_W-1:0];
                REG_MOTION:    cfg_next.motion_threshold    = pwdata[MAG_W-1:0];
                REG_LIGHT:     cfg_next.light_still_seconds = pwdata[CNT_W-1:0];
                REG_DEEP:      cfg_next.deep_still_seconds  = pwdata[CNT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_WIN_START: prdata = 32'(cfg_reg.window_start_hour);
            REG_WIN_END:   prdata = 32'(cfg_reg.window_end_hour);
            REG_MOTION:    prdata = 32'(cfg_reg.motion_threshold);
            REG_LIGHT:     prdata = 32'(cfg_reg.light_still_seconds);
            REG_DEEP:      prdata = 32'(cfg_reg.deep_still_seconds);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register each cycle the
    // result register is empty or being drained.
    // ------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // ------------------------------------------------------------------
    // Per-sample update
    // ------------------------------------------------------------------
    smc_step u_step
    (
        .cfg        (cfg_reg),
        .sample     (sample_reg),
        .state      (state_reg),
        .state_next (state_next),
        .status     (status)
    );

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg.accel_x        <= s_tdata[15:0];
            sample_reg.accel_y        <= s_tdata[31:16];
            sample_reg.accel_z        <= s_tdata[47:32];
            sample_reg.step_total     <= s_tdata[63:48];
            sample_reg.hour_of_day    <= s_tdata[68:64];
            sample_reg.minute_of_hour <= s_tdata[74:69];
            sample_reg.is_charging    <= s_tuser[0];
            sample_reg.is_worn        <= s_tuser[1];
        end
        if (advance)
        begin
            save_reg  <= status.save_record;
            deep_reg  <= state_next.deep_total;
            light_reg <= state_next.light_total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {light_reg, deep_reg};
    assign m_tuser  = save_reg;

`ifndef SYNTHESIS
    // the seconds counter never leaves 0..59
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.second_phase <= PHASE_LAST)
        else $error("second_phase out of range");

    // a nightly clear leaves zero totals and a disarmed window
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && status.night_clear |=>
            state_reg.deep_total == '0 && state_reg.light_total == '0
            && !state_reg.armed_mark && state_reg.second_phase == PHASE_W'(1))
        else $error("nightly clear did not reset totals");

    // totals only move down through a nightly clear
    a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !status.night_clear |=>
            state_reg.deep_total >= $past(state_reg.deep_total)
            && state_reg.light_total >= $past(state_reg.light_total))
        else $error("sleep totals decreased without a clear");

    // counting happens only on a minute tick
    a_count_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        advance && status.counted |-> state_reg.second_phase == '0)
        else $error("minute counted off the minute tick");

    // the registered result matches the state it was taken from
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid && m_tdata == {state_reg.light_total, state_reg.deep_total})
        else $error("result register out of step with totals");
`endif

endmodule

// ===== dv/tb_sleep_minute_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sleep_minute_classifier
// Self-checking bench for the sleep minute classifier.
// ----------------------------------------------------------------------------
// Samples are queued by the stimulus process and sent by a clocked driver with
// random gaps. Each accepted sample is run through a behavioral copy of the
// night tracker, and the expected totals are compared with every result
// transfer. The run walks through several register settings: reset values, a
// window wrapping past midnight, the all-zero extreme, a quiet stretch under
// the top stillness thresholds, and random settings. The receiver stalls at
// random and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_sleep_minute_classifier;
    import smc_pkg::*;

    // register byte addresses
    localparam logic [4:0] REG_WINDOW_START = 5'd0;
    localparam logic [4:0] REG_WINDOW_END   = 5'd4;
    localparam logic [4:0] REG_MOTION_THR   = 5'd8;
    localparam logic [4:0] REG_LIGHT_SECS   = 5'd12;
    localparam logic [4:0] REG_DEEP_SECS    = 5'd16;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_AT     = 60;   // sample count that starts the long hold
    localparam int unsigned HOLD_LEN    = 400;
    localparam int unsigned QUIET_RUN   = 100;  // back-to-back still samples at top thresholds

    typedef struct packed {
        logic              save_record;
        logic [CNT_W-1:0]  deep_minutes;
        logic [CNT_W-1:0]  light_minutes;
    } totals_t;

    typedef struct {
        sample_t     smp;
        int unsigned gap;
    } queued_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] step_total,
    // [68:64] hour_of_day, [74:69] minute_of_hour, [79:75] zero
    logic [79:0] s_tdata = '0;
    // [0] is_charging, [1] is_worn
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] deep_minutes, [31:16] light_minutes
    logic [31:0] m_tdata;
    // [0] save_record
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sleep_minute_classifier u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // register image as the block should hold it
    cfg_t           night_cfg;
    // tracker state advanced on accepted samples (checking side)
    state_t         night_state = '0;
    // tracker state advanced as samples are queued (lets stimulus aim at minute ticks)
    state_t         plan_state = '0;

    queued_sample_t pending_samples[$];
    totals_t        expected_totals[$];
    sample_t        driven_sample;
    int unsigned    gap_wait = 0;
    int unsigned    samples_sent = 0;

    int unsigned    rx_stall = 0;
    int unsigned    rx_taken = 0;
    logic           rx_fast = 1'b0;
    int unsigned    hold_left = 0;
    logic           hold_done = 1'b0;

    int unsigned    fail_count = 0;
    int unsigned    results_checked = 0;
    int unsigned    saves_seen = 0;
    int unsigned    peak_deep = 0;
    int unsigned    peak_light = 0;
    int unsigned    cycle_count = 0;

    // stimulus context kept across phases
    int             base_x = 0;
    int             base_y = 0;
    int             base_z = 0;
    logic [15:0]    walk_steps = '0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral night tracker: one accepted-or-ignored sample per call.
    // ------------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void advance_night(inout state_t st, input cfg_t c,
                                          input sample_t s, output totals_t r);
        int                 sum;
        logic [MAG_W-1:0]   mag;
        logic [MAG_W-1:0]   diff;
        logic [PHASE_W-1:0] nxt;
        logic               walked;
        r.save_record = 1'b0;
        // charging or off the wrist: nothing moves
        if (!s.is_charging && s.is_worn) begin
            sum  = $signed(s.accel_x) + $signed(s.accel_y) + $signed(s.accel_z);
            mag  = MAG_W'((sum < 0) ? -sum : sum);
            diff = (mag > st.prev_magnitude) ? mag - st.prev_magnitude
                                             : st.prev_magnitude - mag;
            if (diff >= c.motion_threshold)
                st.still_count = '0;
            else
                st.still_count = bump(st.still_count);
            st.prev_magnitude = mag;

            nxt = (st.second_phase >= PHASE_LAST) ? '0 : st.second_phase + 1'b1;

            // minute tick
            if (st.second_phase == '0) begin
                walked = (st.prev_steps < s.step_total) && (st.prev_steps != '0);
                if (walked || st.moved_mark)
                    st.moved_mark = !st.moved_mark || walked;

                // window may wrap past midnight
                if (s.hour_of_day >= c.window_start_hour ||
                    s.hour_of_day < c.window_end_hour) begin
                    if (s.hour_of_day == c.window_start_hour && s.minute_of_hour == '0) begin
                        // nightly clear, once per arming
                        if (st.armed_mark) begin
                            st.armed_mark     = 1'b0;
                            st.prev_magnitude = '0;
                            st.still_count    = '0;
                            st.moved_mark     = 1'b0;
                            st.deep_total     = '0;
                            st.light_total    = '0;
                            nxt               = PHASE_W'(1);
                            r.save_record     = 1'b1;
                        end
                    end else begin
                        st.armed_mark = 1'b1;
                        if (st.prev_steps == s.step_total &&
                            st.still_count >= c.light_still_seconds) begin
                            if (st.still_count >= c.deep_still_seconds)
                                st.deep_total = bump(st.deep_total);
                            else
                                st.light_total = bump(st.light_total);
                            r.save_record = 1'b1;
                        end
                    end
                end
            end

            st.second_phase = nxt;
            st.prev_steps   = s.step_total;
        end
        r.deep_minutes  = st.deep_total;
        r.light_minutes = st.light_total;
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver: pops the pending queue, honors each sample's gap.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid     <= 1'b0;
            s_tdata      <= '0;
            s_tuser      <= '0;
            samples_sent <= 0;
            gap_wait     = 0;
            night_state  = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                totals_t got;
                advance_night(night_state, night_cfg, driven_sample, got);
                expected_totals.push_back(got);
                samples_sent <= samples_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && gap_wait >= pending_samples[0].gap) begin
                    driven_sample = pending_samples.pop_front().smp;
                    gap_wait      = 0;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, driven_sample.minute_of_hour, driven_sample.hour_of_day,
                                 driven_sample.step_total, driven_sample.accel_z,
                                 driven_sample.accel_y, driven_sample.accel_x};
                    s_tuser  <= {driven_sample.is_worn, driven_sample.is_charging};
                end else begin
                    if (pending_samples.size() != 0)
                        gap_wait++;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stall per transfer, bursts with none,
    // and the long hold from its own counter.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_taken <= 0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_taken <= rx_taken + 1;
                if (rx_fast || ((rx_taken / 50) % 4) == 2)
                    rx_stall = 0;
                else
                    rx_stall = $urandom_range(0, 15);
            end else if (rx_stall != 0) begin
                rx_stall = rx_stall - 1;
            end
            m_tready <= (rx_stall == 0) && (hold_left == 0);
        end
    end

    // long hold-off: input keeps coming, so the block must fill and stall it
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && samples_sent == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input totals_t want);
        fail_count++;
        if (fail_count <= 10)
            $display({"ERROR @%0t: %s: expected save=%0b deep=%0d light=%0d, ",
                      "got save=%0b deep=%0d light=%0d"},
                     $realtime, what, want.save_record, want.deep_minutes, want.light_minutes,
                     m_tuser, m_tdata[15:0], m_tdata[31:16]);
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            totals_t want;
            if (expected_totals.size() == 0) begin
                note_mismatch("result with nothing outstanding", '0);
            end else begin
                want = expected_totals.pop_front();
                results_checked++;
                if (m_tuser !== want.save_record || m_tdata[15:0] !== want.deep_minutes ||
                    m_tdata[31:16] !== want.light_minutes)
                    note_mismatch("totals mismatch", want);
                if (want.save_record)
                    saves_seen++;
                if (want.deep_minutes > peak_deep)
                    peak_deep = 32'(want.deep_minutes);
                if (want.light_minutes > peak_light)
                    peak_light = 32'(want.light_minutes);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_totals.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_WINDOW_START: night_cfg.window_start_hour   = value[HOUR_W-1:0];
            REG_WINDOW_END:   night_cfg.window_end_hour     = value[HOUR_W-1:0];
            REG_MOTION_THR:   night_cfg.motion_threshold    = value[MAG_W-1:0];
            REG_LIGHT_SECS:   night_cfg.light_still_seconds = value[CNT_W-1:0];
            REG_DEEP_SECS:    night_cfg.deep_still_seconds  = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int unsigned start_hr, input int unsigned end_hr,
                                  input int unsigned thr, input int unsigned light_s,
                                  input int unsigned deep_s);
        write_reg(REG_WINDOW_START, start_hr);
        write_reg(REG_WINDOW_END, end_hr);
        write_reg(REG_MOTION_THR, thr);
        write_reg(REG_LIGHT_SECS, light_s);
        write_reg(REG_DEEP_SECS, deep_s);
        plan_state = night_state;
        // fresh resting posture per setting
        base_x = int'($urandom_range(0, 16000)) - 8000;
        base_y = int'($urandom_range(0, 16000)) - 8000;
        base_z = int'($urandom_range(0, 16000)) - 8000;
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic drain();
        while (pending_samples.size() != 0 || s_tvalid || expected_totals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic sample_t make_sample(input logic [15:0] x, input logic [15:0] y,
                                            input logic [15:0] z, input logic [15:0] steps,
                                            input int unsigned hr, input int unsigned mn,
                                            input logic charging, input logic worn);
        sample_t s;
        s.accel_x        = x;
        s.accel_y        = y;
        s.accel_z        = z;
        s.step_total     = steps;
        s.hour_of_day    = HOUR_W'(hr);
        s.minute_of_hour = MINUTE_W'(mn);
        s.is_charging    = charging;
        s.is_worn        = worn;
        return s;
    endfunction

    task automatic queue_sample(input sample_t s, input int unsigned gap);
        queued_sample_t q;
        totals_t        unused;
        advance_night(plan_state, night_cfg, s, unused);
        q.smp = s;
        q.gap = gap;
        pending_samples.push_back(q);
    endtask

    // Mostly quiet nights with small jitter, steady steps and ticks aimed at
    // the window; the rest jolts, walking, ignored samples and plain noise.
    task automatic plan_samples(input int unsigned count);
        sample_t     s;
        int unsigned r;
        int unsigned jit;
        int unsigned gap;
        int unsigned hr;
        int unsigned mn;
        for (int unsigned k = 0; k < count; k++) begin
            r   = $urandom_range(0, 99);
            gap = (((k / 40) % 4) == 1) ? 0 : $urandom_range(0, 15);
            jit = night_cfg.motion_threshold / 8;
            if (jit > 2000)
                jit = 2000;

            hr = $urandom_range(0, 23);
            mn = $urandom_range(0, 59);
            if (plan_state.second_phase == '0) begin
                // next accepted sample is a minute tick
                if ($urandom_range(0, 99) < 30) begin
                    hr = 32'(night_cfg.window_start_hour);
                    mn = 0;
                end
            end

            if ($urandom_range(0, 99) < 3)
                walk_steps = walk_steps + 16'($urandom_range(1, 20));

            if (r < 4) begin
                // ignored: charging, off the wrist, or both
                s = make_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                hr, mn, 1'b1, 1'b1);
                case ($urandom_range(0, 2))
                    0: s.is_worn = 1'b0;
                    1: s.is_charging = 1'b0;
                    default: ;
                endcase
                if (s.is_charging && !s.is_worn)
                    ;
                else if (!s.is_charging)
                    s.is_worn = 1'b0;
            end else if (r < 12) begin
                s = make_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                hr, mn, 1'b0, 1'b1);
            end else if (r < 17) begin
                // jolt
                s = make_sample(16'($urandom), 16'($urandom), 16'($urandom), walk_steps,
                                hr, mn, 1'b0, 1'b1);
            end else begin
                s = make_sample(16'(base_x + int'($urandom_range(0, 2 * jit)) - int'(jit)),
                                16'(base_y + int'($urandom_range(0, 2 * jit)) - int'(jit)),
                                16'(base_z + int'($urandom_range(0, 2 * jit)) - int'(jit)),
                                walk_steps, hr, mn, 1'b0, 1'b1);
            end
            queue_sample(s, gap);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        night_cfg.window_start_hour   = HOUR_W'(20);
        night_cfg.window_end_hour     = HOUR_W'(8);
        night_cfg.motion_threshold    = MAG_W'(120);
        night_cfg.light_still_seconds = CNT_W'(60);
        night_cfg.deep_still_seconds  = CNT_W'(600);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset register values ---
        // first tick lands on window start, minute 0, before arming: no clear
        queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 20, 0, 1'b0, 1'b1), 0);
        // magnitude extremes
        queue_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 23, 59, 1'b0, 1'b1), 3);
        queue_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h0000, 0, 0, 1'b0, 1'b1), 0);
        queue_sample(make_sample(16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 7, 1, 1'b0, 1'b1), 1);
        // ignored samples
        queue_sample(make_sample(16'h1234, 16'h8765, 16'h7FFF, 16'hFFFF, 21, 30, 1'b1, 1'b1), 0);
        queue_sample(make_sample(16'h8000, 16'h7FFF, 16'h4321, 16'h00FF, 2, 15, 1'b0, 1'b0), 0);
        queue_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00, 12, 45, 1'b1, 1'b0), 2);
        // alternating bit patterns on every field
        queue_sample(make_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 21, 42, 1'b0, 1'b1), 0);
        queue_sample(make_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 10, 21, 1'b0, 1'b1), 0);
        queue_sample(make_sample(16'hFFFF, 16'h0001, 16'h0000, 16'h5555, 16, 32, 1'b0, 1'b1), 5);
        // motion threshold boundary: change of 119 stays still, 120 restarts
        queue_sample(make_sample(16'h0000, 16'h0000, 16'd1000, 16'h5555, 3, 0, 1'b0, 1'b1), 0);
        queue_sample(make_sample(16'h0000, 16'h0000, 16'd1119, 16'h5555, 3, 0, 1'b0, 1'b1), 0);
        queue_sample(make_sample(16'h0000, 16'h0000, 16'd1239, 16'h5555, 3, 0, 1'b0, 1'b1), 0);
        queue_sample(make_sample(16'h0000, 16'h0000, 16'd1239, 16'h5555, 3, 0, 1'b0, 1'b1), 0);
        // negative sum with same magnitude counts as no change
        queue_sample(make_sample(16'h0000, 16'hFB29, 16'h0000, 16'h5555, 3, 0, 1'b0, 1'b1), 0);
        queue_sample(make_sample(16'h0000, 16'hFB2A, 16'h0000, 16'h5555, 3, 0, 1'b0, 1'b1), 0);
        for (int i = 0; i < 6; i++)
            queue_sample(make_sample(16'h0010, 16'hFFF0, 16'h0001, 16'h5555, 4, i, 1'b0, 1'b1),
                         $urandom_range(0, 15));
        walk_steps = 16'h5555;
        plan_samples(250);
        drain();

        // --- window wrapping past midnight, shorter stillness ---
        apply_settings(22, 6, 200, 20, 90);
        plan_samples(300);
        drain();

        // --- all registers at zero: always in window, never still, every counted tick deep ---
        apply_settings(0, 0, 0, 0, 0);
        plan_samples(150);
        drain();

        // --- high settings, stillness limits at their top: a still stretch that stays short of counting ---
        apply_settings(23, 23, 98304, 65535, 65535);
        rx_fast <= 1'b1;
        for (int unsigned i = 0; i < QUIET_RUN; i++)
            queue_sample(make_sample(16'd100, 16'hFFD8, 16'd7, walk_steps, 3, 30, 1'b0, 1'b1), 0);
        drain();
        rx_fast <= 1'b0;

        // --- random settings ---
        apply_settings($urandom_range(0, 23), $urandom_range(0, 23), $urandom_range(1, 400),
                       $urandom_range(1, 40), $urandom_range(1, 120));
        plan_samples(300);
        drain();

        $display("Checked %0d results over five register settings, %0d with save_record set.",
                 results_checked, saves_seen);
        $display("Peak totals deep %0d / light %0d; %0d back-to-back still samples at top limits.",
                 peak_deep, peak_light, QUIET_RUN);
        if (fail_count == 0 && expected_totals.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
